### hdl/thermostat_setback_controller_unit_assert.svh
// Assertion macros shared by the thermostat setback controller RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
// Depends on: nothing; the user module provides clk and rst.
`ifndef THERMOSTAT_SETBACK_CONTROLLER_UNIT_ASSERT_SVH
`define THERMOSTAT_SETBACK_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define TSC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tsc assertion failed");
// Next-cycle implication
`define TSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tsc assertion failed");
`else
`define TSC_ASSERT_NOW(label, pre, post)
`define TSC_ASSERT_NEXT(label, pre, post)
`endif

`endif

### hdl/tsc_pkg.sv
// Package for the thermostat setback controller: codes, constants, state types.
// Used by tsc_step and thermostat_setback_controller_unit.
`timescale 1ns / 1ps

package tsc_pkg;

  // Event codes
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_INCREASE    = 3'd1,
    OP_DECREASE    = 3'd2,
    OP_POWER_CLICK = 3'd3,
    OP_POWER_HOLD  = 3'd4,
    OP_REMOTE_MODE = 3'd5,
    OP_REMOTE_SP   = 3'd6,
    OP_REMOTE_AWAY = 3'd7
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_SP   = 3'd0,
    CFG_MAX_SP   = 3'd1,
    CFG_HYST     = 3'd2,
    CFG_INTERVAL = 3'd3,
    CFG_SYNC     = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // All temperatures in tenths of a degree C
  localparam logic signed [12:0] STEP_TENTHS   = 13'sd5;
  localparam logic signed [13:0] FREEZE_TENTHS = -14'sd200;
  localparam logic signed [11:0] HOME_RESET    = 12'sd190;
  localparam logic signed [11:0] AWAY_RESET    = 12'sd180;

  localparam logic signed [11:0] MIN_SP_RESET   = 12'sd50;
  localparam logic signed [11:0] MAX_SP_RESET   = 12'sd300;
  localparam logic [7:0]         HYST_RESET     = 8'd5;
  localparam logic [31:0]        INTERVAL_RESET = 32'd10000;

  typedef struct packed {
    logic signed [11:0] min_sp;
    logic signed [11:0] max_sp;
    logic [7:0]         hyst;
    logic [31:0]        interval;
    logic               sync;
  } cfg_t;

  typedef struct packed {
    logic               power;
    logic               away;
    logic               heater;
    logic signed [11:0] home_sp;
    logic signed [11:0] away_sp;
    logic [31:0]        counter;
  } state_t;

  typedef struct packed {
    logic               heater_on;
    logic               power_on;
    logic               away_on;
    logic signed [11:0] active_setpoint;
    logic               heater_changed;
    logic               mode_changed;
    logic               away_changed;
    logic               setpoint_changed;
    logic               forward_to_peer;
  } result_t;

endpackage

### hdl/tsc_step.sv
// Next-state and result logic for one thermostat event.
// Purely combinational; depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_step (
  input  tsc_pkg::cfg_t           cfg,
  input  tsc_pkg::state_t         st,
  input  tsc_pkg::op_t            operation,
  input  logic signed [11:0]      temperature,
  input  logic signed [11:0]      value,
  output tsc_pkg::state_t         st_next,
  output tsc_pkg::result_t        res
);
  import tsc_pkg::*;

  logic signed [11:0] active;
  logic signed [12:0] active13;
  logic signed [12:0] prop;
  logic               prop_en;
  logic               prop_ok;
  logic signed [13:0] temp14;
  logic signed [13:0] margin;
  logic [31:0]        cnt_inc;
  logic               power_req_en;
  logic               power_req;
  logic               mc;
  logic               ac;
  logic               sc;
  logic signed [11:0] active_next;

  assign active   = st.away ? st.away_sp : st.home_sp;
  assign active13 = {active[11], active};
  assign temp14   = {{2{temperature[11]}}, temperature};
  // temp - active + hyst; heater turns on when this is <= 0
  assign margin   = temp14 - $signed({{2{active[11]}}, active})
                  + $signed({6'b0, cfg.hyst});
  assign cnt_inc  = (st.power && (st.counter != '1)) ? st.counter + 32'd1 : st.counter;

  // Setpoint proposal source
  always_comb begin
    prop_en = 1'b0;
    prop    = {value[11], value};
    unique case (operation)
      OP_INCREASE: begin
        prop_en = st.power;
        prop    = active13 + STEP_TENTHS;
      end
      OP_DECREASE: begin
        prop_en = st.power;
        prop    = active13 - STEP_TENTHS;
      end
      OP_REMOTE_SP: prop_en = 1'b1;
      default: prop_en = 1'b0;
    endcase
  end

  assign prop_ok = prop_en && (prop != active13)
                && (prop <= $signed({cfg.max_sp[11], cfg.max_sp}))
                && (prop >= $signed({cfg.min_sp[11], cfg.min_sp}));

  // Power requests
  always_comb begin
    power_req_en = 1'b0;
    power_req    = st.power;
    unique case (operation)
      OP_POWER_CLICK: begin
        power_req_en = !st.power;
        power_req    = 1'b1;
      end
      OP_POWER_HOLD: begin
        power_req_en = 1'b1;
        power_req    = !st.power;
      end
      OP_REMOTE_MODE: begin
        power_req_en = 1'b1;
        power_req    = (value == 12'sd1);
      end
      default: power_req_en = 1'b0;
    endcase
  end

  // State update
  always_comb begin
    st_next = st;
    mc = 1'b0;
    ac = 1'b0;
    sc = 1'b0;
    if (operation == OP_TICK) begin
      st_next.counter = cnt_inc;
      if (temp14 <= FREEZE_TENTHS) begin
        st_next.heater = 1'b0;
      end else if (st.power && (cnt_inc >= cfg.interval)) begin
        if (margin <= 14'sd0) begin
          st_next.heater = 1'b1;
        end else if (temp14 >= $signed({{2{active[11]}}, active})) begin
          st_next.heater = 1'b0;
        end
        st_next.counter = '0;
      end
    end
    if (power_req_en && (power_req != st.power)) begin
      st_next.power   = power_req;
      st_next.counter = '0;
      if (!power_req) begin
        st_next.heater = 1'b0;
      end
      mc = 1'b1;
    end
    if ((operation == OP_POWER_CLICK) && st.power) begin
      st_next.away = !st.away;
      ac = 1'b1;
    end
    if ((operation == OP_REMOTE_AWAY) && ((value == 12'sd1) != st.away)) begin
      st_next.away = !st.away;
      ac = 1'b1;
    end
    if (prop_ok) begin
      sc = 1'b1;
      if (st.away) begin
        st_next.away_sp = prop[11:0];
      end else begin
        st_next.home_sp = prop[11:0];
      end
    end
  end

  assign active_next = st_next.away ? st_next.away_sp : st_next.home_sp;

  // Result of this event
  always_comb begin
    res.heater_on        = st_next.heater;
    res.power_on         = st_next.power;
    res.away_on          = st_next.away;
    res.active_setpoint  = active_next;
    res.heater_changed   = st_next.heater != st.heater;
    res.mode_changed     = mc;
    res.away_changed     = ac;
    res.setpoint_changed = sc;
    res.forward_to_peer  = cfg.sync && (mc || ac || sc)
                        && ((operation == OP_INCREASE) || (operation == OP_DECREASE)
                         || (operation == OP_POWER_CLICK) || (operation == OP_POWER_HOLD));
  end

endmodule

### hdl/thermostat_setback_controller_unit.sv
// Thermostat setback controller: an input transaction passes through the input register, then the result register.
// Throughput one transaction per cycle; the input register and the result register
// both advance unless the result is stalled, and tsc_step is the only logic between them.
// Reset (rst, synchronous, active high) restores registers to defaults, state to
// power off, away off, heater off, setpoints 19.0/18.0 C, and empties the pipeline.
// Top level; depends on tsc_pkg, tsc_step and the assertion macro header.
`timescale 1ns / 1ps

`include "thermostat_setback_controller_unit_assert.svh"

module thermostat_setback_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Input transaction
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] operation, [14:3] temperature, [26:15] value, [31:27] zero
  input  logic [31:0]                        s_tdata,
  // Result transaction
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] heater_on, [1] power_on, [2] away_on, [14:3] active_setpoint,
  // [15] heater_changed, [16] mode_changed, [17] away_changed,
  // [18] setpoint_changed, [19] forward_to_peer, [23:20] zero
  output logic [23:0]                        m_tdata,
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tsc_pkg::*;

  cfg_t               cfg;
  state_t             st;
  state_t             st_next;
  result_t            res;
  result_t            out_q;
  logic               in_valid;
  op_t                in_op;
  logic signed [11:0] in_temp;
  logic signed [11:0] in_val;
  logic               out_stall;
  logic               advance;

  assign out_stall = m_tvalid && !m_tready;
  assign advance   = in_valid && !out_stall;
  assign s_tready  = !in_valid || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_sp   <= MIN_SP_RESET;
      cfg.max_sp   <= MAX_SP_RESET;
      cfg.hyst     <= HYST_RESET;
      cfg.interval <= INTERVAL_RESET;
      cfg.sync     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SP:   cfg.min_sp   <= cfg_wdata[11:0];
        CFG_MAX_SP:   cfg.max_sp   <= cfg_wdata[11:0];
        CFG_HYST:     cfg.hyst     <= cfg_wdata[7:0];
        CFG_INTERVAL: cfg.interval <= cfg_wdata[31:0];
        CFG_SYNC:     cfg.sync     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= op_t'(s_tdata[2:0]);
      in_temp <= s_tdata[14:3];
      in_val  <= s_tdata[26:15];
    end
  end

  tsc_step u_step (
    .cfg         (cfg),
    .st          (st),
    .operation   (in_op),
    .temperature (in_temp),
    .value       (in_val),
    .st_next     (st_next),
    .res         (res)
  );

  // Controller state, updated once per event
  always_ff @(posedge clk) begin
    if (rst) begin
      st.power   <= 1'b0;
      st.away    <= 1'b0;
      st.heater  <= 1'b0;
      st.home_sp <= HOME_RESET;
      st.away_sp <= AWAY_RESET;
      st.counter <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!out_stall) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_tdata = {4'b0, out_q.forward_to_peer, out_q.setpoint_changed, out_q.away_changed,
                    out_q.mode_changed, out_q.heater_changed, out_q.active_setpoint,
                    out_q.away_on, out_q.power_on, out_q.heater_on};

  // Checks
  `TSC_ASSERT_NOW(a_heater_needs_power, !st.power, !st.heater)
  `TSC_ASSERT_NOW(a_counter_idle_off, !st.power, st.counter == '0)
  `TSC_ASSERT_NOW(a_result_matches_state, m_tvalid,
    (out_q.power_on == st.power) && (out_q.away_on == st.away)
    && (out_q.heater_on == st.heater))
  `TSC_ASSERT_NOW(a_forward_needs_sync, m_tvalid && out_q.forward_to_peer, cfg.sync)
  `TSC_ASSERT_NEXT(a_state_holds_on_stall, !advance, $stable(st))

endmodule

### tb/thermostat_setback_controller_unit_tb.sv
// Self-checking testbench for thermostat_setback_controller_unit: a short table of
// directed events, then randomized phases under several register settings.
// Depends on tsc_pkg and the thermostat_setback_controller_unit RTL.
`timescale 1ns / 1ps

module thermostat_setback_controller_unit_tb;
  import tsc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int FREEZE_LIMIT = -200;
  localparam int BUTTON_STEP  = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  thermostat_setback_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Thermostat shadow state and register copies
  bit          pw = 1'b0;
  bit          aw = 1'b0;
  bit          ht = 1'b0;
  int          home_sp = 190;
  int          away_sp = 180;
  logic [31:0] tick_count = '0;
  int          lo_sp = 50;
  int          hi_sp = 300;
  int          hyst_cfg = 5;
  logic [31:0] interval_cfg = 32'd10000;
  bit          sync_cfg = 1'b0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      calm = 1'b0;   // no idling on either side while set

  typedef struct {
    bit          is_cfg;
    op_t         op;
    int          temp;
    int          val;
    cfg_idx_t    idx;
    logic [31:0] data;
    bit          typed;
    result_t     want;
  } step_row_t;

  step_row_t event_table[$];

  function automatic int active_sp();
    return aw ? away_sp : home_sp;
  endfunction

  function automatic void switch_heater(input bit on, inout bit hc);
    if (on != ht) begin
      ht = on;
      hc = 1'b1;
    end
  endfunction

  function automatic void switch_power(input bit on, inout bit hc, inout bit mc);
    if (on != pw) begin
      if (!on) switch_heater(1'b0, hc);
      pw = on;
      tick_count = '0;
      mc = 1'b1;
    end
  endfunction

  // Accept only a new in-range value for whichever setpoint is active
  function automatic void offer_setpoint(input int t, inout bit sc);
    if (t != active_sp() && t <= hi_sp && t >= lo_sp) begin
      if (aw) away_sp = t;
      else home_sp = t;
      sc = 1'b1;
    end
  endfunction

  // Advance the shadow thermostat by one event and return the status it reports
  function automatic result_t thermostat_next(op_t op, int temp, int val);
    result_t r;
    int      act;
    bit      hc, mc, ac, sc;
    hc = 1'b0;
    mc = 1'b0;
    ac = 1'b0;
    sc = 1'b0;
    act = active_sp();
    case (op)
      OP_TICK: begin
        if (pw && tick_count != 32'hFFFF_FFFF) tick_count++;
        if (temp <= FREEZE_LIMIT) begin
          switch_heater(1'b0, hc);
        end else if (pw && tick_count >= interval_cfg) begin
          if (temp - act <= -hyst_cfg) switch_heater(1'b1, hc);
          else if (temp >= act) switch_heater(1'b0, hc);
          tick_count = '0;
        end
      end
      OP_INCREASE: if (pw) offer_setpoint(act + BUTTON_STEP, sc);
      OP_DECREASE: if (pw) offer_setpoint(act - BUTTON_STEP, sc);
      OP_POWER_CLICK: begin
        if (pw) begin
          aw = !aw;
          ac = 1'b1;
        end else begin
          switch_power(1'b1, hc, mc);
        end
      end
      OP_POWER_HOLD:  switch_power(!pw, hc, mc);
      OP_REMOTE_MODE: switch_power(val == 1, hc, mc);
      OP_REMOTE_SP:   offer_setpoint(val, sc);
      default: begin
        if (aw != (val == 1)) begin
          aw = (val == 1);
          ac = 1'b1;
        end
      end
    endcase
    r.heater_on        = ht;
    r.power_on         = pw;
    r.away_on          = aw;
    r.active_setpoint  = 12'(active_sp());
    r.heater_changed   = hc;
    r.mode_changed     = mc;
    r.away_changed     = ac;
    r.setpoint_changed = sc;
    r.forward_to_peer  = sync_cfg && op inside {OP_INCREASE, OP_DECREASE, OP_POWER_CLICK,
                                                OP_POWER_HOLD} && (mc || ac || sc);
    return r;
  endfunction

  function automatic result_t outcome(bit h, bit p, bit a, int sp,
                                      bit hc, bit mc, bit ac, bit sc, bit fw);
    result_t r;
    r.heater_on        = h;
    r.power_on         = p;
    r.away_on          = a;
    r.active_setpoint  = 12'(sp);
    r.heater_changed   = hc;
    r.mode_changed     = mc;
    r.away_changed     = ac;
    r.setpoint_changed = sc;
    r.forward_to_peer  = fw;
    return r;
  endfunction

  // Empty table row
  function automatic step_row_t blank_row();
    step_row_t row;
    row.is_cfg = 1'b0;
    row.op     = OP_TICK;
    row.temp   = 0;
    row.val    = 0;
    row.idx    = CFG_MIN_SP;
    row.data   = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic void add_event(op_t op, int temp, int val);
    step_row_t row;
    row = blank_row();
    row.op = op;
    row.temp = temp;
    row.val = val;
    event_table.push_back(row);
  endfunction

  function automatic void add_checked(op_t op, int temp, int val, result_t want);
    step_row_t row;
    row = blank_row();
    row.op = op;
    row.temp = temp;
    row.val = val;
    row.typed = 1'b1;
    row.want = want;
    event_table.push_back(row);
  endfunction

  function automatic void add_reg_write(cfg_idx_t idx, logic [31:0] data);
    step_row_t row;
    row = blank_row();
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    event_table.push_back(row);
  endfunction

  // Input side: optional gap, then hold the transaction until it is taken
  task automatic send_event(op_t op, int temp, int val, bit typed, result_t want);
    result_t predicted;
    if (!calm && $urandom_range(0, 99) < 4) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, 12'(val), 12'(temp), op};
    do @(posedge clk); while (!s_tready);
    predicted = thermostat_next(op, temp, val);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Let every outstanding result come back before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MIN_SP:   lo_sp = int'($signed(data[11:0]));
      CFG_MAX_SP:   hi_sp = int'($signed(data[11:0]));
      CFG_HYST:     hyst_cfg = int'(data[7:0]);
      CFG_INTERVAL: interval_cfg = data;
      CFG_SYNC:     sync_cfg = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int lo, int hi, int hyst, logic [31:0] interval, bit sync);
    drain();
    write_reg(CFG_MIN_SP, 32'(lo));
    write_reg(CFG_MAX_SP, 32'(hi));
    write_reg(CFG_HYST, 32'(hyst));
    write_reg(CFG_INTERVAL, interval);
    write_reg(CFG_SYNC, 32'(sync));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly events near the current setpoint so heater decisions and accepted
  // setpoints happen often; the rest spans temperatures -1270 to 1250 and the full value field
  task automatic random_event(output op_t op, output int temp, output int val);
    int pick, act, r;
    act  = active_sp();
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_TICK;
    else if (pick < 50) op = OP_INCREASE;
    else if (pick < 60) op = OP_DECREASE;
    else if (pick < 68) op = OP_POWER_CLICK;
    else if (pick < 74) op = OP_POWER_HOLD;
    else if (pick < 82) op = OP_REMOTE_MODE;
    else if (pick < 92) op = OP_REMOTE_SP;
    else                op = OP_REMOTE_AWAY;

    r = $urandom_range(0, 9);
    if (r < 7) begin
      temp = act - hyst_cfg - 20 + int'($urandom_range(0, hyst_cfg + 40));
      if (temp < -1270) temp = -1270;
      if (temp > 1250) temp = 1250;
    end else if (r == 7) begin
      temp = int'($urandom_range(0, 1080)) - 1270;
    end else begin
      temp = int'($urandom_range(0, 2520)) - 1270;
    end

    r   = $urandom_range(0, 9);
    val = int'($urandom_range(0, 4095)) - 2048;
    if (op inside {OP_REMOTE_MODE, OP_REMOTE_AWAY}) begin
      if (r < 7) val = $urandom_range(0, 1);
    end else if (op == OP_REMOTE_SP) begin
      if (r < 4 && lo_sp <= hi_sp) val = lo_sp + int'($urandom_range(0, hi_sp - lo_sp));
      else if (r < 6) val = act - 5 + int'($urandom_range(0, 10));
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(logic [23:0] d);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: unexpected result transaction, expected none actual %h", $time, d);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("heater_on", int'(want.heater_on), int'(d[0]));
      check_field("power_on", int'(want.power_on), int'(d[1]));
      check_field("away_on", int'(want.away_on), int'(d[2]));
      check_field("active_setpoint", int'($signed(want.active_setpoint)),
                  int'($signed(d[14:3])));
      check_field("heater_changed", int'(want.heater_changed), int'(d[15]));
      check_field("mode_changed", int'(want.mode_changed), int'(d[16]));
      check_field("away_changed", int'(want.away_changed), int'(d[17]));
      check_field("setpoint_changed", int'(want.setpoint_changed), int'(d[18]));
      check_field("forward_to_peer", int'(want.forward_to_peer), int'(d[19]));
    end
  endtask

  // Output side: check each accepted transaction, stall now and then
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    m_tready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    op_t         op;
    int          temp, val, lo, hi, hyst, count;
    logic [31:0] interval;
    bit          sync;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events from reset, registers at their reset values
    add_checked(OP_TICK, 0, 0, outcome(0, 0, 0, 190, 0, 0, 0, 0, 0));
    add_checked(OP_INCREASE, 0, 0, outcome(0, 0, 0, 190, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_SP, 0, 300, outcome(0, 0, 0, 300, 0, 0, 0, 1, 0));
    add_checked(OP_REMOTE_SP, 0, 301, outcome(0, 0, 0, 300, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_SP, 0, 300, outcome(0, 0, 0, 300, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_SP, 0, 50, outcome(0, 0, 0, 50, 0, 0, 0, 1, 0));
    add_checked(OP_REMOTE_SP, 0, 49, outcome(0, 0, 0, 50, 0, 0, 0, 0, 0));
    add_checked(OP_POWER_CLICK, 0, 0, outcome(0, 1, 0, 50, 0, 1, 0, 0, 0));
    add_checked(OP_DECREASE, 0, 0, outcome(0, 1, 0, 50, 0, 0, 0, 0, 0));
    add_checked(OP_INCREASE, 0, 0, outcome(0, 1, 0, 55, 0, 0, 0, 1, 0));
    add_checked(OP_POWER_CLICK, 0, 0, outcome(0, 1, 1, 180, 0, 0, 1, 0, 0));
    add_checked(OP_REMOTE_AWAY, 0, 0, outcome(0, 1, 0, 55, 0, 0, 1, 0, 0));
    add_checked(OP_REMOTE_AWAY, 0, 1, outcome(0, 1, 1, 180, 0, 0, 1, 0, 0));
    add_checked(OP_POWER_HOLD, 0, 0, outcome(0, 0, 1, 180, 0, 1, 0, 0, 0));
    add_checked(OP_REMOTE_MODE, 0, 2, outcome(0, 0, 1, 180, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_MODE, 0, 1, outcome(0, 1, 1, 180, 0, 1, 0, 0, 0));
    // freeze limit, temperature extremes before the interval expires, out-of-range remote setpoints
    add_checked(OP_TICK, -200, 0, outcome(0, 1, 1, 180, 0, 0, 0, 0, 0));
    add_checked(OP_TICK, 1250, 0, outcome(0, 1, 1, 180, 0, 0, 0, 0, 0));
    add_checked(OP_TICK, -1270, 0, outcome(0, 1, 1, 180, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_SP, 0, -2048, outcome(0, 1, 1, 180, 0, 0, 0, 0, 0));
    add_checked(OP_REMOTE_SP, 0, 2047, outcome(0, 1, 1, 180, 0, 0, 0, 0, 0));
    // decide on every tick: hysteresis edge, dead band, setpoint reached
    add_reg_write(CFG_INTERVAL, 32'd0);
    add_checked(OP_TICK, 175, 0, outcome(1, 1, 1, 180, 1, 0, 0, 0, 0));
    add_event(OP_TICK, 179, 0);
    add_checked(OP_TICK, 180, 0, outcome(0, 1, 1, 180, 1, 0, 0, 0, 0));
    // peer forwarding: button change, remote change, power off with heater on
    add_reg_write(CFG_SYNC, 32'd1);
    add_event(OP_POWER_CLICK, 0, 0);
    add_event(OP_REMOTE_AWAY, 0, 1);
    add_event(OP_TICK, -100, 0);
    add_event(OP_POWER_HOLD, 0, 0);

    foreach (event_table[i]) begin
      if (event_table[i].is_cfg) begin
        drain();
        write_reg(event_table[i].idx, event_table[i].data);
        @(posedge clk);
        cfg_we <= 1'b0;
      end else begin
        send_event(event_table[i].op, event_table[i].temp, event_table[i].val,
                   event_table[i].typed, event_table[i].want);
      end
    end

    // Random phases, one register setting each
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin lo = -550; hi = 1250; hyst = 0;   interval = 0;            sync = 1;
                 count = 250; end
        1: begin lo = 50;   hi = 300;  hyst = 255; interval = 1;            sync = 0;
                 count = 250; end
        2: begin lo = 300;  hi = 50;   hyst = 5;   interval = 3;            sync = 1;
                 count = 150; end
        3: begin lo = 100;  hi = 100;  hyst = 10;  interval = 32'hFFFF_FFFF; sync = 0;
                 count = 100; end
        default: begin
          lo = int'($urandom_range(0, 1150)) - 550;
          hi = lo + int'($urandom_range(0, 600));
          if (hi > 1250) hi = 1250;
          hyst = $urandom_range(0, 40);
          interval = $urandom_range(0, 6);
          sync = 1'($urandom_range(0, 1));
          count = 220;
        end
      endcase
      calm = (p == 0);
      apply_settings(lo, hi, hyst, interval, sync);
      repeat (count) begin
        random_event(op, temp, val);
        send_event(op, temp, val, 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
